// ===== rtl/snc_pkg.sv =====
// snc_pkg: shared types and codes for the skeleton node classifier
// used by snc_ctrl, snc_datapath and the top level; depends on nothing
package snc_pkg;

    localparam int CFG_W   = 9;
    localparam int COORD_W = 8;
    localparam int COLOR_W = 8;
    localparam int COUNT_W = 4;
    localparam int KIND_W  = 2;

    localparam logic [COLOR_W-1:0] WHITE_LEVEL = 8'hFF;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // request function codes
    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    // node kind codes
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENDPOINT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRANCH   = 2'd2;

    typedef enum logic [1:0] {
        ROW_ABOVE  = 2'd0,
        ROW_CENTRE = 2'd1,
        ROW_BELOW  = 2'd2
    } snc_row_sel_t;

    typedef struct packed {
        logic         capture;
        logic         map_wr;
        logic         rd_en;
        snc_row_sel_t rd_sel;
        logic         cap_top;
        logic         cap_mid;
        logic         load_out;
    } snc_cmd_t;

    typedef struct packed {
        logic req_oor;
        logic req_write;
        logic out_free;
    } snc_status_t;

endpackage

// ===== rtl/snc_ctrl.sv =====
// snc_ctrl: request sequencer, one request at a time
// depends on snc_pkg for the command and status structs
module snc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  snc_pkg::snc_status_t status,
    output snc_pkg::snc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RD_MID = 4'b0010,
        ST_RD_BOT = 4'b0100,
        ST_FINISH = 4'b1000
    } snc_state_t;

    snc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.rd_sel = snc_pkg::ROW_CENTRE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (status.req_oor) begin
                        state_next = ST_FINISH;
                    end else if (status.req_write) begin
                        cmd.map_wr = 1'b1;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = snc_pkg::ROW_ABOVE;
                        state_next = ST_RD_MID;
                    end
                end
            end
            ST_RD_MID: begin
                cmd.cap_top = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = snc_pkg::ROW_CENTRE;
                state_next  = ST_RD_BOT;
            end
            ST_RD_BOT: begin
                cmd.cap_mid = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = snc_pkg::ROW_BELOW;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // bottom row stays in the read register until the result slot frees
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/snc_datapath.sv =====
// snc_datapath: frame registers, row-wide white map memory, neighbour count, result register
// depends on snc_pkg for codes, widths and the command and status structs
module snc_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [snc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               s_func,
    input  logic [snc_pkg::COORD_W-1:0]        s_pos_x,
    input  logic [snc_pkg::COORD_W-1:0]        s_pos_y,
    input  logic [snc_pkg::COLOR_W-1:0]        s_red,
    input  logic [snc_pkg::COLOR_W-1:0]        s_green,
    input  logic [snc_pkg::COLOR_W-1:0]        s_blue,
    input  snc_pkg::snc_cmd_t                  cmd,
    output snc_pkg::snc_status_t               status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [snc_pkg::COUNT_W-1:0]        m_neighbour_count,
    output logic [snc_pkg::KIND_W-1:0]         m_node_kind,
    output logic                               m_out_of_range
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WB   = $clog2(MAX_WIDTH + 1);
    localparam int HB   = $clog2(MAX_HEIGHT + 1);
    localparam int SB   = (WB > HB) ? WB : HB;
    localparam int EW   = (SB > snc_pkg::CFG_W) ? SB : snc_pkg::CFG_W;

    logic [snc_pkg::CFG_W-1:0]   frame_width_reg, frame_height_reg;
    logic [EW-1:0]               eff_w, eff_h;
    logic                        in_oor, in_white;

    logic [MAX_WIDTH-1:0]        map_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0]        rd_data_reg;
    logic [RW-1:0]               rd_row;

    logic [snc_pkg::COORD_W-1:0] x_reg, y_reg, y_now;
    logic                        oor_reg;
    logic                        left_ok, right_ok, up_ok, down_ok;
    logic [CW-1:0]               col_l, col_c, col_r;
    logic [2:0]                  row_bits;
    logic [2:0]                  top_reg, mid_reg;
    logic [7:0]                  nbrs;
    logic [snc_pkg::COUNT_W-1:0] count;
    logic [snc_pkg::KIND_W-1:0]  kind;

    logic                        m_valid_reg;
    logic [snc_pkg::COUNT_W-1:0] count_reg;
    logic [snc_pkg::KIND_W-1:0]  kind_reg;
    logic                        m_oor_reg;

    // frame size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= snc_pkg::CFG_W'(256);
            frame_height_reg <= snc_pkg::CFG_W'(256);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                snc_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                snc_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
            endcase
        end
    end

    // frame size in use, limited to 1 .. max
    always_comb begin
        eff_w = EW'(frame_width_reg);
        if (frame_width_reg == '0) begin
            eff_w = EW'(1);
        end else if (EW'(frame_width_reg) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end
        eff_h = EW'(frame_height_reg);
        if (frame_height_reg == '0) begin
            eff_h = EW'(1);
        end else if (EW'(frame_height_reg) > EW'(MAX_HEIGHT)) begin
            eff_h = EW'(MAX_HEIGHT);
        end
    end

    assign in_oor   = (EW'(s_pos_x) >= eff_w) || (EW'(s_pos_y) >= eff_h);
    assign in_white = (s_red == snc_pkg::WHITE_LEVEL) && (s_green == snc_pkg::WHITE_LEVEL)
                      && (s_blue == snc_pkg::WHITE_LEVEL);

    assign status.req_oor   = in_oor;
    assign status.req_write = (s_func == snc_pkg::FUNC_WRITE);
    assign status.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg   <= s_pos_x;
            y_reg   <= s_pos_y;
            oor_reg <= in_oor;
        end
    end

    // neighbour position checks against the frame
    assign left_ok  = (x_reg != '0);
    assign right_ok = (EW'(x_reg) + EW'(1)) < eff_w;
    assign up_ok    = (y_reg != '0);
    assign down_ok  = (EW'(y_reg) + EW'(1)) < eff_h;

    assign col_c = CW'(x_reg);
    assign col_l = left_ok ? CW'(x_reg - 8'd1) : col_c;
    assign col_r = right_ok ? CW'(EW'(x_reg) + EW'(1)) : col_c;

    // the row above is addressed straight from the request as it is taken
    assign y_now = cmd.capture ? s_pos_y : y_reg;

    always_comb begin
        case (cmd.rd_sel)
            snc_pkg::ROW_ABOVE:  rd_row = (y_now != '0) ? RW'(y_now - 8'd1) : RW'(y_now);
            snc_pkg::ROW_CENTRE: rd_row = RW'(y_reg);
            snc_pkg::ROW_BELOW:  rd_row = down_ok ? RW'(EW'(y_reg) + EW'(1)) : RW'(y_reg);
            default:             rd_row = RW'(y_reg);
        endcase
    end

    // map memory, one row per word, bit writes
    always_ff @(posedge aclk) begin
        if (cmd.map_wr) begin
            map_mem[RW'(s_pos_y)][CW'(s_pos_x)] <= in_white;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= map_mem[rd_row];
        end
    end

    assign row_bits = {rd_data_reg[col_r] & right_ok, rd_data_reg[col_c],
                       rd_data_reg[col_l] & left_ok};

    always_ff @(posedge aclk) begin
        if (cmd.cap_top) begin
            top_reg <= row_bits & {3{up_ok}};
        end
        if (cmd.cap_mid) begin
            mid_reg <= row_bits;
        end
    end

    assign nbrs = {top_reg, mid_reg[2], mid_reg[0], row_bits & {3{down_ok}}};

    always_comb begin
        count = '0;
        for (int i = 0; i < 8; i++) begin
            count = count + snc_pkg::COUNT_W'(nbrs[i]);
        end
        if (oor_reg || !mid_reg[1]) begin
            count = '0;
        end
        case (count)
            snc_pkg::COUNT_W'(1): kind = snc_pkg::KIND_ENDPOINT;
            snc_pkg::COUNT_W'(3): kind = snc_pkg::KIND_BRANCH;
            default:              kind = snc_pkg::KIND_NONE;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            count_reg <= count;
            kind_reg  <= kind;
            m_oor_reg <= oor_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_neighbour_count = count_reg;
    assign m_node_kind       = kind_reg;
    assign m_out_of_range    = m_oor_reg;

endmodule

// ===== rtl/skeleton_node_classifier.sv =====
// skeleton_node_classifier: top level, joins the sequencer and the datapath
// depends on snc_pkg, snc_ctrl and snc_datapath
//
// Keeps a one-bit white map of the frame in a memory of MAX_HEIGHT rows, each MAX_WIDTH
// bits wide, and answers one request at a time. A write request inside the frame
// returns no result. As the map has a single read port, a classify request reads the
// rows above, at and below the centre one per cycle and then forms the count in the
// finish state. A request outside the frame skips to the finish state and returns its
// flag. A result held in the output register while the sink stalls lets the next write
// request be taken; a request with a result waits in the finish state. The map has no
// reset and needs no clearing pass; reading a pixel never written is undefined.
module skeleton_node_classifier #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [snc_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [snc_pkg::COORD_W-1:0] s_pos_x,
    input  logic [snc_pkg::COORD_W-1:0] s_pos_y,
    input  logic [snc_pkg::COLOR_W-1:0] s_red,
    input  logic [snc_pkg::COLOR_W-1:0] s_green,
    input  logic [snc_pkg::COLOR_W-1:0] s_blue,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [snc_pkg::COUNT_W-1:0] m_neighbour_count,
    output logic [snc_pkg::KIND_W-1:0]  m_node_kind,
    output logic                        m_out_of_range
);

    snc_pkg::snc_cmd_t    cmd;
    snc_pkg::snc_status_t status;

    snc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    snc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_func            (s_func),
        .s_pos_x           (s_pos_x),
        .s_pos_y           (s_pos_y),
        .s_red             (s_red),
        .s_green           (s_green),
        .s_blue            (s_blue),
        .cmd               (cmd),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_neighbour_count (m_neighbour_count),
        .m_node_kind       (m_node_kind),
        .m_out_of_range    (m_out_of_range)
    );

endmodule

// ===== rtl/snc_checker.sv =====
// snc_checker: port-level assertions for skeleton_node_classifier, bound to the top level
// depends on snc_pkg for codes and widths
module snc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_func,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [snc_pkg::COUNT_W-1:0] m_neighbour_count,
    input logic [snc_pkg::KIND_W-1:0]  m_node_kind,
    input logic                        m_out_of_range
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_neighbour_count)
            && $stable(m_node_kind) && $stable(m_out_of_range))
        else $error("stalled result changed");

    // node kind agrees with the count
    a_kind_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_node_kind == snc_pkg::KIND_ENDPOINT) == (m_neighbour_count == 4'd1))
            && ((m_node_kind == snc_pkg::KIND_BRANCH) == (m_neighbour_count == 4'd3)))
        else $error("node kind does not match count");

    // an out-of-range flag carries an empty result
    a_oor_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_neighbour_count == '0
            && m_node_kind == snc_pkg::KIND_NONE)
        else $error("out-of-range result not empty");

    // a classify request occupies the block past its accept cycle
    a_classify_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == snc_pkg::FUNC_CLASSIFY |=> !s_ready)
        else $error("ready right after a classify request");

endmodule

bind skeleton_node_classifier snc_checker u_snc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_func            (s_func),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_neighbour_count (m_neighbour_count),
    .m_node_kind       (m_node_kind),
    .m_out_of_range    (m_out_of_range)
);

// ===== test/tb_skeleton_node_classifier.sv =====
// tb_skeleton_node_classifier: self-checking testbench for the skeleton node classifier
// directed and random write/classify requests under several frame sizes and idle patterns;
// depends on snc_pkg and skeleton_node_classifier
`timescale 1ns / 100ps

module tb_skeleton_node_classifier;

    localparam int MAP_COLS = 256;
    localparam int MAP_ROWS = 256;
    localparam int PHASE_ITEMS = 155;

    localparam int W_CFG [0:8] = '{3, 1, 256, 12, 256, 511, 40, 2, 256};
    localparam int H_CFG [0:8] = '{3, 256, 1, 9, 256, 0, 511, 5, 256};

    // tracks the white map and frame size, predicts and holds pending results
    class skeleton_tracker;
        typedef struct packed {
            logic [snc_pkg::COUNT_W-1:0] count;
            logic [snc_pkg::KIND_W-1:0]  kind;
            logic                        oor;
        } node_result_t;

        bit           white_px [0:MAP_COLS*MAP_ROWS-1];
        int           cols = MAP_COLS;
        int           rows = MAP_ROWS;
        node_result_t due_results[$];
        int           errors = 0;

        function void set_frame(int w, int h);
            cols = (w < 1) ? 1 : (w > MAP_COLS) ? MAP_COLS : w;
            rows = (h < 1) ? 1 : (h > MAP_ROWS) ? MAP_ROWS : h;
        endfunction

        function void take_request(logic func, logic [7:0] x, logic [7:0] y,
                                   logic [7:0] r, logic [7:0] g, logic [7:0] b);
            node_result_t res;
            int nx, ny, dx, dy, cnt;
            res = '0;
            cnt = 0;
            if (int'(x) >= cols || int'(y) >= rows) begin
                res.oor = 1'b1;
                due_results.insert(due_results.size(), res);
                return;
            end
            if (func == snc_pkg::FUNC_WRITE) begin
                white_px[int'(x) + int'(y) * MAP_COLS] =
                    (r == snc_pkg::WHITE_LEVEL && g == snc_pkg::WHITE_LEVEL
                     && b == snc_pkg::WHITE_LEVEL);
                return;
            end
            if (white_px[int'(x) + int'(y) * MAP_COLS]) begin
                for (dy = -1; dy <= 1; dy++) begin
                    for (dx = -1; dx <= 1; dx++) begin
                        nx = int'(x) + dx;
                        ny = int'(y) + dy;
                        if (dx == 0 && dy == 0) continue;
                        if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
                        if (white_px[nx + ny * MAP_COLS]) cnt++;
                    end
                end
            end
            res.count = snc_pkg::COUNT_W'(cnt);
            res.kind  = (cnt == 1) ? snc_pkg::KIND_ENDPOINT :
                        (cnt == 3) ? snc_pkg::KIND_BRANCH : snc_pkg::KIND_NONE;
            due_results.insert(due_results.size(), res);
        endfunction

        function void check_result(logic [snc_pkg::COUNT_W-1:0] cnt,
                                   logic [snc_pkg::KIND_W-1:0] kind, logic oor);
            node_result_t want;
            if (due_results.size() == 0) begin
                $error("result with no request pending: count %0d kind %0d out_of_range %0d",
                       cnt, kind, oor);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (cnt !== want.count) begin
                $error("neighbour_count: expected %0d, got %0d", want.count, cnt);
                errors++;
            end
            if (kind !== want.kind) begin
                $error("node_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (oor !== want.oor) begin
                $error("out_of_range: expected %0d, got %0d", want.oor, oor);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic                          cfg_addr = snc_pkg::REG_FRAME_WIDTH;
    logic [snc_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_func = snc_pkg::FUNC_WRITE;
    logic [snc_pkg::COORD_W-1:0]   s_pos_x = '0;
    logic [snc_pkg::COORD_W-1:0]   s_pos_y = '0;
    logic [snc_pkg::COLOR_W-1:0]   s_red = '0;
    logic [snc_pkg::COLOR_W-1:0]   s_green = '0;
    logic [snc_pkg::COLOR_W-1:0]   s_blue = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [snc_pkg::COUNT_W-1:0]   m_neighbour_count;
    logic [snc_pkg::KIND_W-1:0]    m_node_kind;
    logic                          m_out_of_range;

    skeleton_tracker sb = new();
    bit              pix_written [0:MAP_COLS*MAP_ROWS-1];
    int              idle_mode = 0;
    int              items_sent = 0;
    logic            pressure_req = 1'b0;
    logic            pressure_done = 1'b0;
    int              hold_left = 0;

    skeleton_node_classifier #(
        .MAX_WIDTH  (MAP_COLS),
        .MAX_HEIGHT (MAP_ROWS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_pos_x           (s_pos_x),
        .s_pos_y           (s_pos_y),
        .s_red             (s_red),
        .s_green           (s_green),
        .s_blue            (s_blue),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_neighbour_count (m_neighbour_count),
        .m_node_kind       (m_node_kind),
        .m_out_of_range    (m_out_of_range)
    );

    always #5 aclk = ~aclk;

    // result sink: random stalls, plus one long hold-off so the block backs up
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (pressure_req && !pressure_done) begin
            m_ready       <= 1'b0;
            hold_left     <= 400;
            pressure_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >=
                        ((idle_mode == 0) ? 75 : (idle_mode == 1) ? 23 : 0));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_neighbour_count, m_node_kind, m_out_of_range);
    end

    task automatic send_req(input logic func, input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 75 : 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < gap_pct);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_pos_x <= x;
        s_pos_y <= y;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_request(func, x, y, r, g, b);
        items_sent++;
    endtask

    task automatic wr(input logic [7:0] x, input logic [7:0] y,
                      input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        if (int'(x) < sb.cols && int'(y) < sb.rows)
            pix_written[int'(x) + int'(y) * MAP_COLS] = 1'b1;
        send_req(snc_pkg::FUNC_WRITE, x, y, r, g, b);
    endtask

    // colour bytes are ignored on classify, so randomize them anyway
    task automatic cls(input logic [7:0] x, input logic [7:0] y);
        send_req(snc_pkg::FUNC_CLASSIFY, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    function automatic logic [23:0] pick_colour(int white_pct);
        logic [23:0] c;
        int          v;
        v = $urandom_range(0, 99);
        c = 24'hFFFFFF;
        if (v >= white_pct) begin
            if (v < white_pct + (100 - white_pct) / 2)
                c[$urandom_range(0, 2) * 8 +: 8] = 8'($urandom_range(0, 254));
            else
                c = 24'($urandom);
        end
        return c;
    endfunction

    // make sure every in-frame pixel a classify may read has been written
    task automatic fill_window(input logic [7:0] x, input logic [7:0] y);
        int          nx, ny, dx, dy;
        logic [23:0] c;
        for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
                nx = int'(x) + dx;
                ny = int'(y) + dy;
                if (nx < 0 || ny < 0 || nx >= sb.cols || ny >= sb.rows) continue;
                if (!pix_written[nx + ny * MAP_COLS]) begin
                    c = pick_colour(70);
                    wr(8'(nx), 8'(ny), c[23:16], c[15:8], c[7:0]);
                end
            end
        end
    endtask

    // drain the block, let a trailing write settle, then program both sizes
    task automatic set_frame(input logic [snc_pkg::CFG_W-1:0] w,
                             input logic [snc_pkg::CFG_W-1:0] h);
        s_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= snc_pkg::REG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_addr  <= snc_pkg::REG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_frame(w, h);
    endtask

    initial begin
        int          ph, n, ox, oy, span_x, span_y, phase_end;
        logic [7:0]  x, y;
        logic [23:0] c;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: corner pixels at the top of the coordinate range, full 256x256 frame
        wr(8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        wr(8'd254, 8'd255, 8'h00, 8'h00, 8'h00);
        wr(8'd255, 8'd254, 8'hFF, 8'hFF, 8'hFF);
        wr(8'd254, 8'd254, 8'hFF, 8'hFF, 8'hFE);
        cls(8'd255, 8'd255);                       // endpoint
        cls(8'd254, 8'd254);                       // centre not white
        wr(8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        wr(8'd1, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        wr(8'd0, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        wr(8'd1, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        cls(8'd0, 8'd0);                           // branch point
        wr(8'd1, 8'd1, 8'hFE, 8'hFF, 8'hFF);
        cls(8'd0, 8'd0);                           // two neighbours, no node

        set_frame(9'd2, 9'd2);
        cls(8'd1, 8'd1);
        wr(8'd1, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        cls(8'd1, 8'd1);
        cls(8'd2, 8'd0);                           // outside the frame
        wr(8'd0, 8'd2, 8'hFF, 8'hFF, 8'hFF);       // outside, map untouched
        wr(8'd255, 8'd255, 8'h00, 8'h00, 8'h00);
        cls(8'd255, 8'd255);

        // zero size acts as one pixel: white centre with no neighbour in frame
        set_frame(9'd0, 9'd0);
        cls(8'd0, 8'd0);
        wr(8'd1, 8'd0, 8'hFF, 8'hFF, 8'hFF);

        // oversize acts as the full frame; the outside write above left this pixel white
        set_frame(9'd511, 9'd300);
        cls(8'd255, 8'd255);

        for (ph = 0; ph < 9; ph++) begin
            set_frame(snc_pkg::CFG_W'(W_CFG[ph]), snc_pkg::CFG_W'(H_CFG[ph]));
            idle_mode = ph / 3;
            if (ph == 6) pressure_req <= 1'b1;
            span_x = (sb.cols > 10) ? 11 : sb.cols + 1;
            span_y = (sb.rows > 10) ? 11 : sb.rows + 1;
            ox = 0;
            oy = 0;
            n = 0;
            // each phase sends at least PHASE_ITEMS requests, fill writes included
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                // move the working patch now and then, often against a frame edge
                if (n % 40 == 0) begin
                    ox = 0;
                    oy = 0;
                    if (sb.cols > 10) begin
                        case ($urandom_range(0, 2))
                            0: ox = 0;
                            1: ox = sb.cols - 10;
                            default: ox = $urandom_range(0, sb.cols - 10);
                        endcase
                    end
                    if (sb.rows > 10) begin
                        case ($urandom_range(0, 2))
                            0: oy = 0;
                            1: oy = sb.rows - 10;
                            default: oy = $urandom_range(0, sb.rows - 10);
                        endcase
                    end
                end
                if ($urandom_range(0, 99) < 5) begin
                    x = 8'($urandom);
                    y = 8'($urandom);
                end else begin
                    x = 8'(ox + $urandom_range(0, span_x - 1));
                    y = 8'(oy + $urandom_range(0, span_y - 1));
                end
                if ($urandom_range(0, 99) < 55) begin
                    if (int'(x) < sb.cols && int'(y) < sb.rows) fill_window(x, y);
                    cls(x, y);
                end else begin
                    c = pick_colour(50);
                    wr(x, y, c[23:16], c[15:8], c[7:0]);
                end
                n++;
            end
        end

        s_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/snc_pkg.sv
rtl/snc_ctrl.sv
rtl/snc_datapath.sv
rtl/skeleton_node_classifier.sv
rtl/snc_checker.sv
test/tb_skeleton_node_classifier.sv
